// ===== sv/fsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Shared widths, constants, stage structures and the Q1.15 rounding multiply.
// ----------------------------------------------------------------------------
`default_nettype none
package fsr_pkg;

   localparam int DIV_STAGES = 16;
   localparam int POW_STAGES = 5;
   localparam int TP_DELAY   = DIV_STAGES - POW_STAGES;
   localparam int NUM_W      = 48;
   localparam int DEN_W      = 33;

   localparam logic [15:0] ONE_Q12 = 16'd4096;
   localparam logic [15:0] ONE_Q15 = 16'd32768;
   localparam logic [15:0] HALF_Q15 = 16'd16384;

   typedef struct packed {
      logic             vld;
      logic [15:0]      c;
      logic [15:0]      ni;
      logic [15:0]      nt;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } front_type;

   typedef struct packed {
      logic        vld;
      logic        tir;
      logic [15:0] p;
   } back_type;

   function automatic logic [15:0] mul_q15(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] prod;
      prod = ({16'd0, a} * {16'd0, b}) + {16'd0, HALF_Q15};
      return prod[30:15];
   endfunction

endpackage
`default_nettype wire

// ===== sv/fsr_front.sv =====
// ----------------------------------------------------------------------------
// Fresnel front end
// Dot product, cosine extraction, index selection and R0 operand setup.
// ----------------------------------------------------------------------------
`default_nettype none
module fsr_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_vld,
   input  wire logic signed [15:0] incident_x,
   input  wire logic signed [15:0] incident_y,
   input  wire logic signed [15:0] incident_z,
   input  wire logic signed [15:0] normal_x,
   input  wire logic signed [15:0] normal_y,
   input  wire logic signed [15:0] normal_z,
   input  wire logic        [15:0] refr_index,
   output fsr_pkg::front_type      front
);

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [31:0] px_ff, py_ff, pz_ff;
   logic [15:0]        idx1_ff, idx2_ff, diff1_ff;
   logic [16:0]        sum1_ff;
   logic signed [33:0] d_ff;
   logic [31:0]        diff2_ff;
   logic [32:0]        sum2_ff;
   fsr_pkg::front_type f_ff, f_in;

   logic [33:0] mag;
   logic [20:0] cq;
   logic        pos;

   always_comb begin
      pos  = !d_ff[33] && (d_ff != 34'sd0);
      mag  = d_ff[33] ? 34'(-d_ff) : 34'(d_ff);
      cq   = mag[33:13];
      f_in.vld = v2_ff;
      f_in.c   = (cq > 21'(fsr_pkg::ONE_Q15)) ? fsr_pkg::ONE_Q15 : cq[15:0];
      f_in.ni  = pos ? idx2_ff : fsr_pkg::ONE_Q12;
      f_in.nt  = pos ? fsr_pkg::ONE_Q12 : idx2_ff;
      f_in.num = {1'b0, diff2_ff, 15'd0} + {16'd0, sum2_ff[32:1]};
      f_in.den = sum2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_vld;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      px_ff    <= normal_x * incident_x;
      py_ff    <= normal_y * incident_y;
      pz_ff    <= normal_z * incident_z;
      idx1_ff  <= refr_index;
      diff1_ff <= (refr_index > fsr_pkg::ONE_Q12) ? refr_index - fsr_pkg::ONE_Q12
                                                  : fsr_pkg::ONE_Q12 - refr_index;
      sum1_ff  <= {1'b0, refr_index} + {1'b0, fsr_pkg::ONE_Q12};
      d_ff     <= 34'(px_ff) + 34'(py_ff) + 34'(pz_ff);
      idx2_ff  <= idx1_ff;
      diff2_ff <= {16'd0, diff1_ff} * {16'd0, diff1_ff};
      sum2_ff  <= 33'({17'd0, sum1_ff} * {17'd0, sum1_ff});
      f_ff     <= f_in;
   end

   always_comb begin
      front     = f_ff;
      front.vld = v3_ff;
   end

endmodule
`default_nettype wire

// ===== sv/fsr_div.sv =====
// ----------------------------------------------------------------------------
// Fresnel R0 divider
// Restoring divider with one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none
module fsr_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_vld,
   input  wire logic [fsr_pkg::NUM_W-1:0]  num,
   input  wire logic [fsr_pkg::DEN_W-1:0]  den,
   output logic                            out_vld,
   output logic [15:0]                     quo
);

   localparam int DS = fsr_pkg::DIV_STAGES;
   localparam int NW = fsr_pkg::NUM_W;
   localparam int DW = fsr_pkg::DEN_W;

   logic          vld_ff [DS];
   logic [NW-1:0] rem_ff [DS];
   logic [NW-1:0] rem_in [DS];
   logic [DW-1:0] den_ff [DS];
   logic [DW-1:0] den_in [DS];
   logic [15:0]   quo_ff [DS];
   logic [15:0]   quo_in [DS];

   always_comb begin
      logic [NW-1:0] rsrc;
      logic [NW-1:0] sh;
      logic [15:0]   qsrc;
      for (int i = 0; i < DS; i++) begin
         rsrc = (i == 0) ? num : rem_ff[(i == 0) ? 0 : i - 1];
         den_in[i] = (i == 0) ? den : den_ff[(i == 0) ? 0 : i - 1];
         qsrc = (i == 0) ? 16'd0 : quo_ff[(i == 0) ? 0 : i - 1];
         sh = {{(NW - DW){1'b0}}, den_in[i]} << (DS - 1 - i);
         if (rsrc >= sh) begin
            rem_in[i] = rsrc - sh;
            quo_in[i] = {qsrc[14:0], 1'b1};
         end else begin
            rem_in[i] = rsrc;
            quo_in[i] = {qsrc[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DS; i++) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= (i == 0) ? in_vld : vld_ff[(i == 0) ? 0 : i - 1];
         end
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_in[i];
         quo_ff[i] <= quo_in[i];
      end
   end

   assign out_vld = vld_ff[DS-1];
   assign quo     = quo_ff[DS-1];

endmodule
`default_nettype wire

// ===== sv/fsr_tirpow.sv =====
// ----------------------------------------------------------------------------
// Fresnel critical angle test and power unit
// Total internal reflection test and (1 - cos)^5, aligned to the divider.
// ----------------------------------------------------------------------------
`default_nettype none
module fsr_tirpow (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fsr_pkg::front_type front,
   output fsr_pkg::back_type       back
);

   localparam int TD = fsr_pkg::TP_DELAY;

   logic        v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic [31:0] ni2_ff, nt2_ff;
   logic [30:0] c2_ff;
   logic [15:0] q4_ff, q5_ff, q6_ff, q7_ff;
   logic [62:0] lhs_ff;
   logic [61:0] rhs_ff;
   logic [15:0] p5_ff, p6_ff, p7_ff, p8_ff;
   logic        tir6_ff, tir7_ff, tir8_ff;
   logic [30:0] omc2;
   fsr_pkg::back_type dly_ff [TD];

   assign omc2 = 31'h4000_0000 - c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else begin
         v4_ff <= front.vld;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
      ni2_ff  <= {16'd0, front.ni} * {16'd0, front.ni};
      nt2_ff  <= {16'd0, front.nt} * {16'd0, front.nt};
      c2_ff   <= 31'({16'd0, front.c} * {16'd0, front.c});
      q4_ff   <= fsr_pkg::ONE_Q15 - front.c;
      lhs_ff  <= 63'({31'd0, ni2_ff} * {32'd0, omc2});
      rhs_ff  <= {nt2_ff, 30'd0};
      p5_ff   <= fsr_pkg::mul_q15(q4_ff, q4_ff);
      q5_ff   <= q4_ff;
      tir6_ff <= lhs_ff >= {1'b0, rhs_ff};
      p6_ff   <= fsr_pkg::mul_q15(p5_ff, q5_ff);
      q6_ff   <= q5_ff;
      tir7_ff <= tir6_ff;
      p7_ff   <= fsr_pkg::mul_q15(p6_ff, q6_ff);
      q7_ff   <= q6_ff;
      tir8_ff <= tir7_ff;
      p8_ff   <= fsr_pkg::mul_q15(p7_ff, q7_ff);
      for (int i = 0; i < TD; i++) begin
         if (i == 0) begin
            dly_ff[i].tir <= tir8_ff;
            dly_ff[i].p   <= p8_ff;
         end else begin
            dly_ff[i].tir <= dly_ff[(i == 0) ? 0 : i - 1].tir;
            dly_ff[i].p   <= dly_ff[(i == 0) ? 0 : i - 1].p;
         end
         if (reset) begin
            dly_ff[i].vld <= 1'b0;
         end else begin
            dly_ff[i].vld <= (i == 0) ? v8_ff : dly_ff[(i == 0) ? 0 : i - 1].vld;
         end
      end
   end

   assign back = dly_ff[TD-1];

endmodule
`default_nettype wire

// ===== sv/fresnel_schlick_reflectance_top.sv =====
// ----------------------------------------------------------------------------
// Fresnel reflectance, Schlick approximation
// The result strobe follows the front end, R0 divider and output registers.
// Throughput is one word per cycle, set by the fully pipelined R0 divider.
// busy is always low; the receiver cannot stall and no stage ever waits.
// Synchronous reset clears all valid bits; no word is in flight after it.
// ----------------------------------------------------------------------------
`default_nettype none
module fresnel_schlick_reflectance_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_incident_x,
   input  wire logic signed [15:0] req_incident_y,
   input  wire logic signed [15:0] req_incident_z,
   input  wire logic signed [15:0] req_normal_x,
   input  wire logic signed [15:0] req_normal_y,
   input  wire logic signed [15:0] req_normal_z,
   input  wire logic        [15:0] req_refr_index,
   output logic                    rsp_strobe,
   output logic             [15:0] rsp_reflectance,
   output logic                    rsp_total_internal
);

   fsr_pkg::front_type front;
   fsr_pkg::back_type  back;
   logic               dv;
   logic [15:0]        r0;
   logic               v1_ff, tir1_ff;
   logic [15:0]        r01_ff;
   logic [30:0]        prod_ff;
   logic [31:0]        prod_full;
   logic [30:0]        sum;

   assign busy = 1'b0;

   fsr_front u_front (
      .clock(clock), .reset(reset), .in_vld(start && !busy),
      .incident_x(req_incident_x), .incident_y(req_incident_y),
      .incident_z(req_incident_z), .normal_x(req_normal_x),
      .normal_y(req_normal_y), .normal_z(req_normal_z),
      .refr_index(req_refr_index), .front(front)
   );

   fsr_div u_div (
      .clock(clock), .reset(reset), .in_vld(front.vld),
      .num(front.num), .den(front.den), .out_vld(dv), .quo(r0)
   );

   fsr_tirpow u_tirpow (
      .clock(clock), .reset(reset), .front(front), .back(back)
   );

   assign prod_full = {16'd0, fsr_pkg::ONE_Q15 - r0} * {16'd0, back.p};
   assign sum = prod_ff + 31'(fsr_pkg::HALF_Q15);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         v1_ff      <= dv && back.vld;
         rsp_strobe <= v1_ff;
      end
      tir1_ff <= back.tir;
      r01_ff  <= r0;
      prod_ff <= prod_full[30:0];
      rsp_total_internal <= tir1_ff;
      rsp_reflectance    <= tir1_ff ? fsr_pkg::ONE_Q15 : r01_ff + sum[30:15];
   end

endmodule
`default_nettype wire

// ===== tb/fresnel_schlick_reflectance_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fresnel reflectance checker
// Watches the command and result channels of the reflectance block. For each
// accepted word it computes the expected reflectance and internal reflection
// flag, then compares every result strobe against the oldest expectation.
// ----------------------------------------------------------------------------
`default_nettype none
module fresnel_schlick_reflectance_check (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic signed [15:0] req_incident_x,
   input  wire logic signed [15:0] req_incident_y,
   input  wire logic signed [15:0] req_incident_z,
   input  wire logic signed [15:0] req_normal_x,
   input  wire logic signed [15:0] req_normal_y,
   input  wire logic signed [15:0] req_normal_z,
   input  wire logic        [15:0] req_refr_index,
   input  wire logic               rsp_strobe,
   input  wire logic        [15:0] rsp_reflectance,
   input  wire logic               rsp_total_internal,
   output int                      error_count,
   output int                      pending_count,
   output int                      result_count,
   output int                      tir_count
);

   typedef struct {
      logic [15:0] refl;
      logic        tir;
   } reflect_type;

   reflect_type want_mem [64];
   logic [5:0]  wr_ptr;
   logic [5:0]  rd_ptr;
   int          fill;

   function automatic logic [63:0] round_q15(input logic [63:0] a, input logic [63:0] b);
      return (a * b + 64'd16384) >> 15;
   endfunction

   function automatic reflect_type schlick(
      input logic signed [15:0] ix, iy, iz, nx, ny, nz,
      input logic [15:0] index);
      reflect_type r;
      logic signed [63:0] dot;
      logic [63:0] ni, nt, mag, c, lhs, rhs, diff, sum, sum2, r0, q, p;
      dot = 64'(nx) * 64'(ix) + 64'(ny) * 64'(iy) + 64'(nz) * 64'(iz);
      if (dot > 0) begin
         ni = 64'(index);
         nt = 64'd4096;
         mag = dot;
      end else begin
         ni = 64'd4096;
         nt = 64'(index);
         mag = -dot;
      end
      c = mag >> 13;
      if (c > 64'd32768) c = 64'd32768;
      lhs = ni * ni * (64'd1 << 30) - ni * ni * (c * c);
      rhs = (nt * nt) << 30;
      if (lhs >= rhs) begin
         r.refl = 16'd32768;
         r.tir = 1'b1;
         return r;
      end
      diff = (ni > nt) ? ni - nt : nt - ni;
      sum = ni + nt;
      sum2 = sum * sum;
      r0 = ((diff * diff << 15) + (sum2 >> 1)) / sum2;
      if (r0 > 64'd32768) r0 = 64'd32768;
      q = 64'd32768 - c;
      p = q;
      for (int k = 0; k < 4; k++) p = round_q15(p, q);
      r.refl = 16'(r0 + (((64'd32768 - r0) * p + 64'd16384) >> 15));
      r.tir = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      reflect_type want;
      int errs;
      errs = 0;
      if (reset) begin
         wr_ptr = '0;
         rd_ptr = '0;
         fill = 0;
         error_count <= 0;
         result_count <= 0;
         tir_count <= 0;
      end else begin
         if (start && !busy) begin
            if (fill == 64) begin
               $display("%0t: too many words in flight", $time);
               errs = errs + 1;
            end else begin
               want_mem[wr_ptr] = schlick(req_incident_x, req_incident_y,
                  req_incident_z, req_normal_x, req_normal_y, req_normal_z,
                  req_refr_index);
               wr_ptr = wr_ptr + 6'd1;
               fill = fill + 1;
            end
         end
         if (rsp_strobe) begin
            result_count <= result_count + 1;
            if (rsp_total_internal) tir_count <= tir_count + 1;
            if (fill == 0) begin
               $display("%0t: unexpected word refl=%0d tir=%0b", $time,
                  rsp_reflectance, rsp_total_internal);
               errs = errs + 1;
            end else begin
               want = want_mem[rd_ptr];
               rd_ptr = rd_ptr + 6'd1;
               fill = fill - 1;
               if (want.refl !== rsp_reflectance || want.tir !== rsp_total_internal) begin
                  $display("%0t: mismatch expected refl=%0d tir=%0b actual refl=%0d tir=%0b",
                     $time, want.refl, want.tir, rsp_reflectance, rsp_total_internal);
                  errs = errs + 1;
               end
            end
         end
         error_count <= error_count + errs;
      end
      pending_count <= fill;
   end

endmodule
`default_nettype wire

// ===== tb/fresnel_schlick_reflectance_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fresnel reflectance testbench
// Drives directed corners and random small and raw vectors into the block,
// with random gaps and back to back, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module fresnel_schlick_reflectance_top_test;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_incident_x = '0, req_incident_y = '0, req_incident_z = '0;
   logic signed [15:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic [15:0] req_refr_index = 16'd4096;
   logic rsp_strobe;
   logic [15:0] rsp_reflectance;
   logic rsp_total_internal;
   int error_count, pending_count, result_count, tir_count;
   int cycle_count = 0;
   int sent_count = 0;

   always #4 clock = ~clock;

   fresnel_schlick_reflectance_top DUT (.*);

   fresnel_schlick_reflectance_check CHECK (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_word(input logic signed [15:0] ix, iy, iz, nx, ny, nz,
                            input logic [15:0] index);
      start <= 1'b1;
      req_incident_x <= ix;
      req_incident_y <= iy;
      req_incident_z <= iz;
      req_normal_x <= nx;
      req_normal_y <= ny;
      req_normal_z <= nz;
      req_refr_index <= index;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic random_word(input int phase);
      logic signed [15:0] v[6];
      logic [15:0] index;
      int sel;
      sel = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) v[i] = 16'($urandom);
      if (sel < 6) begin
         for (int i = 0; i < 3; i++) begin
            v[i] = 16'($signed($urandom_range(0, 9460)) - 4730);
            v[i + 3] = 16'($signed($urandom_range(0, 9460)) - 4730);
         end
      end
      case ($urandom_range(0, 3))
         0: index = 16'($urandom);
         1: index = 16'($urandom_range(4096, 12288));
         2: index = 16'($urandom_range(1, 4096));
         default: index = 16'($urandom_range(0, 65535));
      endcase
      if (index == 0) index = 16'd1;
      if (phase == 0) idle_gap();
      send_word(v[0], v[1], v[2], v[3], v[4], v[5], index);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_word(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd6144);
      send_word(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd6144);
      send_word(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'd6144);
      send_word(16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'd6144);
      send_word(16'sd15000, 16'sd0, 16'sd6600, 16'sd0, 16'sd0, 16'sd16384, 16'd6144);
      send_word(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd0);
      send_word(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd0);
      send_word(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd65535);
      send_word(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd65535);
      send_word(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd1);
      send_word(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd4096);
      send_word(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                -16'sd32768, 16'd6144);
      send_word(16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768,
                -16'sd32768, 16'd6144);
      send_word(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                16'sd32767, 16'd32768);
      send_word(16'sd100, -16'sd200, 16'sd300, 16'sd400, 16'sd500, -16'sd600, 16'd5000);
      send_word(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 16'hAAAA);
      send_word(-16'sd21846, 16'sd21845, -16'sd21846, 16'sd21845, -16'sd21846,
                16'sd21845, 16'h5555);
      for (int n = 0; n < 250; n++) random_word(0);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      for (int n = 0; n < 150; n++) random_word(1);
      for (int n = 0; n < 250; n++) random_word(0);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d words; %0d results checked, %0d with internal reflection.",
               sent_count, result_count, tir_count);
      if (error_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
